// File: hdl/tct_pkg.sv
// shared types and constants of the touch contact tracker
package tct_pkg;

  // input command codes, carried on in_tuser
  typedef enum logic [1:0] {
    CMD_SET         = 2'd0,
    CMD_ALIVE_ID    = 2'd1,
    CMD_ALIVE_EMPTY = 2'd2,
    CMD_UNUSED      = 2'd3
  } cmd_t;

  // event codes, carried on out_tuser
  typedef enum logic [1:0] {
    EV_DOWN    = 2'd0,
    EV_MOVED   = 2'd1,
    EV_UP      = 2'd2,
    EV_DROPPED = 2'd3
  } ev_kind_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_SET_FIN,
    ST_SWP_RD,
    ST_SWP_CHK,
    ST_SWP_FLUSH
  } state_t;

  localparam int ID_W  = 32;
  localparam int POS_W = 16;
  localparam int CNT_W = 6;

  // one table entry as held in the contact ram
  typedef struct packed {
    logic [31:0] shape;   // width, height
    logic [47:0] motion;  // accel, vel_y, vel_x
    logic [15:0] y;
    logic [15:0] x;
    logic [31:0] id;
  } entry_t;

  localparam int IN_DATA_W  = 144;
  localparam int OUT_DATA_W = 72;

endpackage

// File: hdl/tct_ram.sv
// generic single-port-write, single-port-read ram with registered read
module tct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/touch_contact_tracker.sv
// touch contact tracker top level: session table, sequencer and event output
//
// input channel (in_*): one transfer is one command. set stores or updates a
// contact, alive-id marks one id as still present (the transfer with in_tlast
// closes the alive message), alive-empty removes every contact.
// output channel (out_*): one transfer per event: down, moved, up or dropped.
// out_tlast flags the final event caused by one command.
// the table lives in a ram walked one entry at a time by a small sequencer:
// each entry passes an address state, then a compare/act state; a set stops
// its scan early when the id is found, and the sweep that closes an alive
// message can also wait on an output stall.
// in_tready is high only while the sequencer is idle.
// up events are held one deep so that the last one can carry out_tlast;
// the output register accepts a new event in the cycle the old one leaves.
// when the receiver stalls, the sequencer waits with the pending event.
// reset clears the contact count, seen marks and output valid; the ram
// needs no clearing since only slots below the count are ever read.
module touch_contact_tracker #(
  parameter int MAX_CONTACTS = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  // input channel
  input  logic         in_tvalid,
  output logic         in_tready,
  // contact_id, pos_x, pos_y, vel_x, vel_y, blob_height, blob_width, accel
  input  logic [143:0] in_tdata,
  input  logic [1:0]   in_tuser,  // command
  input  logic         in_tlast,  // last_id
  // result channel
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_id, out_x, out_y, active_count, zero pad
  output logic [71:0]  out_tdata,
  output logic [1:0]   out_tuser, // event_kind
  output logic         out_tlast  // last_event
);

  localparam int AW  = $clog2(MAX_CONTACTS);
  localparam int CW  = $clog2(MAX_CONTACTS + 1);
  localparam int OCW = tct_pkg::CNT_W;
  localparam int EW  = $bits(tct_pkg::entry_t);

  tct_pkg::state_t state_r, state_nxt;

  // captured command
  tct_pkg::cmd_t cmd_r;
  logic [31:0]   id_r;
  logic [15:0]   px_r, py_r;
  logic [47:0]   mot_r;
  logic [31:0]   shp_r;
  logic          last_r;

  logic [CW-1:0]           idx_r, w_r, rem_r, cnt_r;
  logic [MAX_CONTACTS-1:0] mark_r;
  tct_pkg::ev_kind_t       ev_kind_r;

  // pending up event
  logic          pend_v_r;
  logic [31:0]   pend_id_r;
  logic [15:0]   pend_x_r, pend_y_r;
  logic [CW-1:0] pend_cnt_r;

  // output register
  logic              out_v_r;
  tct_pkg::ev_kind_t out_kind_r;
  logic [31:0]       out_id_r;
  logic [15:0]       out_x_r, out_y_r;
  logic [OCW-1:0]    out_cnt_r;
  logic              out_last_r;

  // ram
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  tct_pkg::entry_t  ram_wdata, rd_entry;
  logic [EW-1:0]    ram_rdata;

  logic in_fire, out_free, scan_end, id_match, keep, remove_all, is_set, room;

  // event to load into the output register
  logic              emit;
  tct_pkg::ev_kind_t e_kind;
  logic [31:0]       e_id;
  logic [15:0]       e_x, e_y;
  logic [CW-1:0]     e_cnt;
  logic              e_last;

  assign in_tready  = (state_r == tct_pkg::ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_free   = !out_v_r || out_tready;
  assign rd_entry   = tct_pkg::entry_t'(ram_rdata);
  assign scan_end   = (idx_r == cnt_r);
  assign id_match   = (rd_entry.id == id_r);
  assign remove_all = (cmd_r == tct_pkg::CMD_ALIVE_EMPTY);
  assign keep       = !remove_all && mark_r[idx_r[AW-1:0]];
  assign is_set     = (cmd_r == tct_pkg::CMD_SET);
  assign room       = (cnt_r < CW'(MAX_CONTACTS));

  tct_ram #(
    .WIDTH(EW),
    .DEPTH(MAX_CONTACTS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(EW'(ram_wdata)),
    .raddr(idx_r[AW-1:0]),
    .rdata(ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tct_pkg::ST_IDLE: begin
        if (in_fire) begin
          unique case (tct_pkg::cmd_t'(in_tuser)) inside
            tct_pkg::CMD_SET, tct_pkg::CMD_ALIVE_ID: state_nxt = tct_pkg::ST_SCAN_RD;
            tct_pkg::CMD_ALIVE_EMPTY:                state_nxt = tct_pkg::ST_SWP_RD;
            default:                                 state_nxt = tct_pkg::ST_IDLE;
          endcase
        end
      end
      tct_pkg::ST_SCAN_RD: begin
        if (!scan_end) begin
          state_nxt = tct_pkg::ST_SCAN_CHK;
        end else if (is_set) begin
          state_nxt = tct_pkg::ST_SET_FIN;
        end else if (last_r) begin
          state_nxt = tct_pkg::ST_SWP_RD;
        end else begin
          state_nxt = tct_pkg::ST_IDLE;
        end
      end
      tct_pkg::ST_SCAN_CHK: begin
        state_nxt = (is_set && id_match) ? tct_pkg::ST_SET_FIN : tct_pkg::ST_SCAN_RD;
      end
      tct_pkg::ST_SET_FIN: begin
        if (out_free) state_nxt = tct_pkg::ST_IDLE;
      end
      tct_pkg::ST_SWP_RD: begin
        state_nxt = scan_end ? tct_pkg::ST_SWP_FLUSH : tct_pkg::ST_SWP_CHK;
      end
      tct_pkg::ST_SWP_CHK: begin
        if (keep || !pend_v_r || out_free) state_nxt = tct_pkg::ST_SWP_RD;
      end
      tct_pkg::ST_SWP_FLUSH: begin
        if (!pend_v_r || out_free) state_nxt = tct_pkg::ST_IDLE;
      end
      default: state_nxt = tct_pkg::ST_IDLE;
    endcase
  end

  // ram writes and event selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_r[AW-1:0];
    ram_wdata = '{shape: shp_r, motion: mot_r, y: py_r, x: px_r, id: id_r};
    emit      = 1'b0;
    e_kind    = ev_kind_r;
    e_id      = id_r;
    e_x       = px_r;
    e_y       = py_r;
    e_cnt     = cnt_r;
    e_last    = 1'b1;
    unique case (state_r)
      tct_pkg::ST_SCAN_RD: begin
        // new id: append at the end of the table
        if (scan_end && is_set && room) begin
          ram_we    = 1'b1;
          ram_waddr = cnt_r[AW-1:0];
        end
      end
      tct_pkg::ST_SCAN_CHK: begin
        ram_we = is_set && id_match;
      end
      tct_pkg::ST_SET_FIN: begin
        emit = out_free;
      end
      tct_pkg::ST_SWP_CHK: begin
        if (keep) begin
          // compact: move the surviving entry down
          ram_we    = 1'b1;
          ram_waddr = w_r[AW-1:0];
          ram_wdata = rd_entry;
        end else begin
          emit   = pend_v_r && out_free;
          e_last = 1'b0;
        end
      end
      tct_pkg::ST_SWP_FLUSH: begin
        emit = pend_v_r && out_free;
      end
      default: begin
      end
    endcase
    if (state_r == tct_pkg::ST_SWP_CHK || state_r == tct_pkg::ST_SWP_FLUSH) begin
      e_kind = tct_pkg::EV_UP;
      e_id   = pend_id_r;
      e_x    = pend_x_r;
      e_y    = pend_y_r;
      e_cnt  = pend_cnt_r;
    end
  end

  // sequencer control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= tct_pkg::ST_IDLE;
      cnt_r    <= '0;
      mark_r   <= '0;
      pend_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        tct_pkg::ST_IDLE: begin
          pend_v_r <= 1'b0;
        end
        tct_pkg::ST_SCAN_RD: begin
          if (scan_end && is_set && room) begin
            mark_r[cnt_r[AW-1:0]] <= 1'b0;
            cnt_r                 <= cnt_r + CW'(1);
          end
        end
        tct_pkg::ST_SCAN_CHK: begin
          if (!is_set && id_match) mark_r[idx_r[AW-1:0]] <= 1'b1;
        end
        tct_pkg::ST_SWP_CHK: begin
          if (!keep && (!pend_v_r || out_free)) pend_v_r <= 1'b1;
        end
        tct_pkg::ST_SWP_FLUSH: begin
          if (!pend_v_r || out_free) begin
            cnt_r    <= w_r;
            mark_r   <= '0;
            pend_v_r <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // command capture, walk counters and pending payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r  <= tct_pkg::cmd_t'(in_tuser);
      id_r   <= in_tdata[31:0];
      px_r   <= in_tdata[47:32];
      py_r   <= in_tdata[63:48];
      mot_r  <= {in_tdata[143:128], in_tdata[95:64]};
      shp_r  <= in_tdata[127:96];
      last_r <= in_tlast;
      idx_r  <= '0;
      w_r    <= '0;
      rem_r  <= cnt_r;
    end
    unique case (state_r)
      tct_pkg::ST_SCAN_RD: begin
        if (scan_end) begin
          idx_r     <= '0;
          ev_kind_r <= room ? tct_pkg::EV_DOWN : tct_pkg::EV_DROPPED;
        end
      end
      tct_pkg::ST_SCAN_CHK: begin
        if (is_set && id_match) begin
          ev_kind_r <= tct_pkg::EV_MOVED;
        end else begin
          idx_r <= idx_r + CW'(1);
        end
      end
      tct_pkg::ST_SWP_CHK: begin
        if (keep) begin
          w_r   <= w_r + CW'(1);
          idx_r <= idx_r + CW'(1);
        end else if (!pend_v_r || out_free) begin
          pend_id_r  <= rd_entry.id;
          pend_x_r   <= rd_entry.x;
          pend_y_r   <= rd_entry.y;
          pend_cnt_r <= rem_r - CW'(1);
          rem_r      <= rem_r - CW'(1);
          idx_r      <= idx_r + CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (emit) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind_r <= e_kind;
      out_id_r   <= e_id;
      out_x_r    <= e_x;
      out_y_r    <= e_y;
      out_cnt_r  <= OCW'({{OCW{1'b0}}, e_cnt});
      out_last_r <= e_last;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {2'b00, out_cnt_r, out_y_r, out_x_r, out_id_r};

endmodule

// File: hdl/tct_checker.sv
// port-level checks of the touch contact tracker and their binding
module tct_checker #(
  parameter int MAX_CONTACTS = 32
) (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [1:0]   in_tuser,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [71:0]  out_tdata,
  input logic [1:0]   out_tuser,
  input logic         out_tlast
);

  localparam logic [5:0] FULL_CNT = 6'(MAX_CONTACTS);

  // a stalled event stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("event withdrawn while stalled");

  // down, moved and dropped are always the only event of their command
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == tct_pkg::EV_DOWN || out_tuser == tct_pkg::EV_MOVED ||
                   out_tuser == tct_pkg::EV_DROPPED) |-> out_tlast)
    else $error("single event without last flag");

  // a real command keeps the input closed for at least the next cycle
  a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser != tct_pkg::CMD_UNUSED |=> !in_tready)
    else $error("input reopened right after a command");

  // a dropped contact means the table is full
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == tct_pkg::EV_DROPPED |-> out_tdata[69:64] == FULL_CNT)
    else $error("dropped event with free room in the table");

endmodule

bind touch_contact_tracker tct_checker #(.MAX_CONTACTS(MAX_CONTACTS)) u_tct_checker (.*);

// File: sim/touch_contact_tracker_test.sv
// testbench for the touch contact tracker: directed table, random touch frames, event checker
`timescale 1ns / 1ps

module touch_contact_tracker_test;

  localparam int TABLE_DEPTH = 32;
  localparam int DIRECTED_CNT = 17;
  localparam int RANDOM_ITEMS = 440;
  localparam int CALM_TAIL = 60;
  localparam int DRAIN_CYCLES = 200;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int REPORT_MAX = 10;

  // one command as the sender sees it
  typedef struct {
    tct_pkg::cmd_t cmd;
    logic [31:0]   id;
    logic [15:0]   px;
    logic [15:0]   py;
    logic [15:0]   vx;
    logic [15:0]   vy;
    logic [15:0]   height;
    logic [15:0]   width;
    logic [15:0]   accel;
    logic          last;
  } touch_item_t;

  // one event as it should leave the block
  typedef struct {
    tct_pkg::ev_kind_t kind;
    logic [31:0]       id;
    logic [15:0]       x;
    logic [15:0]       y;
    logic              last;
    logic [5:0]        cnt;
  } contact_event_t;

  // directed stimulus row, with a hand-typed event where it is obvious
  typedef struct {
    touch_item_t    item;
    bit             typed;
    contact_event_t ev;
  } directed_row_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [143:0] in_tdata;   // contact_id, pos_x, pos_y, vel_x, vel_y, height, width, accel
  logic [1:0]   in_tuser;   // command
  logic         in_tlast;   // last_id
  logic         out_tvalid;
  logic         out_tready;
  logic [71:0]  out_tdata;  // out_id, out_x, out_y, active_count, zero pad
  logic [1:0]   out_tuser;  // event_kind
  logic         out_tlast;  // last_event

  // predictor copy of the contact table
  logic [31:0] tbl_id [TABLE_DEPTH];
  logic [15:0] tbl_x [TABLE_DEPTH];
  logic [15:0] tbl_y [TABLE_DEPTH];
  logic [47:0] tbl_motion [TABLE_DEPTH];
  logic [31:0] tbl_shape [TABLE_DEPTH];
  bit          tbl_seen [TABLE_DEPTH];
  int          tbl_cnt;
  int          tbl_peak;

  contact_event_t step_events[$];     // events of the command just accepted
  contact_event_t pending_events[$];  // events still owed by the block
  directed_row_t  directed_rows[$];

  contact_event_t got_ev;
  contact_event_t want_ev;
  int  fail_count;
  int  sent_items;
  int  cycle_count;
  int  stall_left;
  int  kind_seen [4];
  bit  tail_calm;

  touch_contact_tracker #(
    .MAX_CONTACTS(TABLE_DEPTH)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic contact_event_t mk_event(tct_pkg::ev_kind_t k, logic [31:0] cid,
                                              logic [15:0] x, logic [15:0] y, logic lst,
                                              int cnt);
    contact_event_t e;
    e.kind = k;
    e.id   = cid;
    e.x    = x;
    e.y    = y;
    e.last = lst;
    e.cnt  = cnt[5:0];
    return e;
  endfunction

  function automatic touch_item_t mk_item(tct_pkg::cmd_t c, logic [31:0] cid,
                                          logic [15:0] px, logic [15:0] py,
                                          logic [15:0] vx, logic [15:0] vy,
                                          logic [15:0] h, logic [15:0] w, logic [15:0] acc,
                                          logic lst);
    touch_item_t r;
    r.cmd    = c;
    r.id     = cid;
    r.px     = px;
    r.py     = py;
    r.vx     = vx;
    r.vy     = vy;
    r.height = h;
    r.width  = w;
    r.accel  = acc;
    r.last   = lst;
    return r;
  endfunction

  // appends one row to the directed table
  function automatic void add_row(touch_item_t it, bit typed, contact_event_t ev);
    directed_row_t r;
    r.item  = it;
    r.typed = typed;
    r.ev    = ev;
    directed_rows.insert(directed_rows.size(), r);
  endfunction

  // random payload; the optional shape and accel fields are often absent (zero)
  function automatic touch_item_t rand_item(tct_pkg::cmd_t c, logic [31:0] cid, logic lst);
    touch_item_t r;
    r = mk_item(c, cid, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom), 16'($urandom), 16'($urandom), lst);
    if ($urandom_range(0, 3) == 0) r.height = '0;
    if ($urandom_range(0, 3) == 0) r.width = '0;
    if ($urandom_range(0, 3) == 0) r.accel = '0;
    return r;
  endfunction

  // session ids: half from a small pool so they collide, half anywhere in 32 bits
  function automatic logic [31:0] pick_session_id();
    if ($urandom_range(0, 1) == 1) return $urandom;
    return $urandom_range(0, 255);
  endfunction

  // predicts the events of one command and updates the table copy
  function automatic void track_contacts(touch_item_t it);
    int i;
    int w;
    int hit;
    int remaining;
    step_events.delete();
    case (it.cmd) inside
      tct_pkg::CMD_SET: begin
        hit = -1;
        for (i = 0; i < tbl_cnt; i++)
          if (hit < 0 && tbl_id[i] == it.id) hit = i;
        if (hit < 0 && tbl_cnt < TABLE_DEPTH) begin
          // new session goes to the end of the table, not yet marked alive
          hit = tbl_cnt;
          tbl_id[hit] = it.id;
          tbl_seen[hit] = 1'b0;
          tbl_cnt++;
          if (tbl_cnt > tbl_peak) tbl_peak = tbl_cnt;
          step_events.insert(step_events.size(),
                             mk_event(tct_pkg::EV_DOWN, it.id, it.px, it.py, 1'b1, tbl_cnt));
        end else if (hit >= 0) begin
          step_events.insert(step_events.size(),
                             mk_event(tct_pkg::EV_MOVED, it.id, it.px, it.py, 1'b1, tbl_cnt));
        end else begin
          // table full: report the input position, keep nothing
          step_events.insert(step_events.size(),
                             mk_event(tct_pkg::EV_DROPPED, it.id, it.px, it.py, 1'b1,
                                      tbl_cnt));
        end
        if (hit >= 0) begin
          tbl_x[hit]      = it.px;
          tbl_y[hit]      = it.py;
          tbl_motion[hit] = {it.accel, it.vy, it.vx};
          tbl_shape[hit]  = {it.width, it.height};
        end
      end
      tct_pkg::CMD_ALIVE_ID, tct_pkg::CMD_ALIVE_EMPTY: begin
        if (it.cmd == tct_pkg::CMD_ALIVE_ID)
          for (i = 0; i < tbl_cnt; i++)
            if (tbl_id[i] == it.id) tbl_seen[i] = 1'b1;
        if (it.cmd == tct_pkg::CMD_ALIVE_EMPTY || it.last) begin
          // sweep: drop unmarked (or all) entries in table order, compact the rest
          w = 0;
          remaining = tbl_cnt;
          for (i = 0; i < tbl_cnt; i++) begin
            if (it.cmd == tct_pkg::CMD_ALIVE_ID && tbl_seen[i]) begin
              tbl_id[w]     = tbl_id[i];
              tbl_x[w]      = tbl_x[i];
              tbl_y[w]      = tbl_y[i];
              tbl_motion[w] = tbl_motion[i];
              tbl_shape[w]  = tbl_shape[i];
              w++;
            end else begin
              remaining--;
              step_events.insert(step_events.size(),
                                 mk_event(tct_pkg::EV_UP, tbl_id[i], tbl_x[i], tbl_y[i],
                                          1'b0, remaining));
            end
          end
          tbl_cnt = w;
          for (i = 0; i < TABLE_DEPTH; i++) tbl_seen[i] = 1'b0;
          if (step_events.size() > 0) step_events[step_events.size() - 1].last = 1'b1;
        end
      end
      default: begin
        // unused code is ignored
      end
    endcase
  endfunction

  // drives one command with an optional idle burst first, predicts on the transfer
  task automatic send_item(touch_item_t it, bit typed, contact_event_t typed_ev);
    @(negedge clk);
    if (!tail_calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.cmd;
    in_tlast  <= it.last;
    in_tdata  <= {it.accel, it.width, it.height, it.vy, it.vx, it.py, it.px, it.id};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    track_contacts(it);
    if (typed) begin
      pending_events.insert(pending_events.size(), typed_ev);
    end else begin
      foreach (step_events[i]) pending_events.insert(pending_events.size(), step_events[i]);
    end
    if (it.cmd != tct_pkg::CMD_UNUSED) sent_items++;
  endtask

  // receiver stalls in random bursts, none in the calm tail
  always @(negedge clk) begin
    if (!rst_n || tail_calm) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 7);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // event checker: every output transfer against the oldest owed event
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_ev = mk_event(tct_pkg::ev_kind_t'(out_tuser), out_tdata[31:0], out_tdata[47:32],
                        out_tdata[63:48], out_tlast, int'(out_tdata[69:64]));
      kind_seen[out_tuser]++;
      if (pending_events.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_MAX)
          $display("%0t: unexpected event kind %0d id %h x %h y %h last %b count %0d",
                   $realtime, got_ev.kind, got_ev.id, got_ev.x, got_ev.y, got_ev.last,
                   got_ev.cnt);
      end else begin
        want_ev = pending_events.pop_front();
        if (got_ev.kind != want_ev.kind || got_ev.id != want_ev.id || got_ev.x != want_ev.x ||
            got_ev.y != want_ev.y || got_ev.last != want_ev.last ||
            got_ev.cnt != want_ev.cnt) begin
          fail_count++;
          if (fail_count <= REPORT_MAX) begin
            $display("%0t: event mismatch", $realtime);
            $display("  expected kind %0d id %h x %h y %h last %b count %0d", want_ev.kind,
                     want_ev.id, want_ev.x, want_ev.y, want_ev.last, want_ev.cnt);
            $display("  actual   kind %0d id %h x %h y %h last %b count %0d", got_ev.kind,
                     got_ev.id, got_ev.x, got_ev.y, got_ev.last, got_ev.cnt);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d events still owed", cycle_count,
               pending_events.size());
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    touch_item_t    alive_msg[$];
    contact_event_t no_ev;
    int             frame_kind;
    int             n_sets;
    int             keep_pct;
    int             k;
    logic [31:0]    sid;

    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = tct_pkg::CMD_SET;
    in_tlast    = 1'b0;
    out_tready  = 1'b1;
    rst_n       = 1'b0;
    fail_count  = 0;
    sent_items  = 0;
    cycle_count = 0;
    stall_left  = 0;
    tail_calm   = 1'b0;
    tbl_cnt     = 0;
    tbl_peak    = 0;
    foreach (kind_seen[i]) kind_seen[i] = 0;
    foreach (tbl_seen[i]) tbl_seen[i] = 1'b0;
    no_ev = mk_event(tct_pkg::EV_DOWN, '0, '0, '0, 1'b0, 0);

    // directed table: extremes, every command, the special cases
    add_row(mk_item(tct_pkg::CMD_SET, 32'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0,
                    16'h0, 1'b0), 1'b1,
            mk_event(tct_pkg::EV_DOWN, 32'h0, 16'h0, 16'h0, 1'b1, 1));
    add_row(mk_item(tct_pkg::CMD_SET, 32'hffff_ffff, 16'hffff, 16'hffff, 16'h8000, 16'h7fff,
                    16'hffff, 16'hffff, 16'h8000, 1'b1), 1'b1,
            mk_event(tct_pkg::EV_DOWN, 32'hffff_ffff, 16'hffff, 16'hffff, 1'b1, 2));
    // known id overwritten: moved
    add_row(mk_item(tct_pkg::CMD_SET, 32'h0, 16'h1234, 16'habcd, 16'h7fff, 16'h8000, 16'h0,
                    16'h1, 16'h7fff, 1'b0), 1'b0, no_ev);
    add_row(mk_item(tct_pkg::CMD_SET, 32'h8000_0001, 16'h8000, 16'h0001, 16'hffff, 16'h0001,
                    16'h5555, 16'haaaa, 16'hffff, 1'b0), 1'b0, no_ev);
    // alive id without the last mark: nothing yet
    add_row(mk_item(tct_pkg::CMD_ALIVE_ID, 32'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0,
                    16'h0, 1'b0), 1'b0, no_ev);
    // set in the middle of an alive message starts unmarked
    add_row(mk_item(tct_pkg::CMD_SET, 32'h55, 16'h00ff, 16'hff00, 16'h0, 16'h0, 16'h0, 16'h0,
                    16'h0, 1'b0), 1'b0, no_ev);
    // unknown alive id is ignored
    add_row(mk_item(tct_pkg::CMD_ALIVE_ID, 32'hdead_beef, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0,
                    16'h0, 16'h0, 1'b0), 1'b0, no_ev);
    // closing id: two up events in table order
    add_row(mk_item(tct_pkg::CMD_ALIVE_ID, 32'hffff_ffff, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0,
                    16'h0, 16'h0, 1'b1), 1'b0, no_ev);
    add_row(mk_item(tct_pkg::CMD_ALIVE_ID, 32'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0,
                    16'h0, 1'b1), 1'b0, no_ev);
    // everything alive: sweep removes nothing
    add_row(mk_item(tct_pkg::CMD_ALIVE_ID, 32'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0,
                    16'h0, 1'b1), 1'b0, no_ev);
    // unused code, even with tlast, does nothing
    add_row(mk_item(tct_pkg::CMD_UNUSED, 32'h0, 16'hffff, 16'hffff, 16'h0, 16'h0, 16'h0,
                    16'h0, 16'h0, 1'b1), 1'b0, no_ev);
    add_row(mk_item(tct_pkg::CMD_ALIVE_EMPTY, 32'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0,
                    16'h0, 16'h0, 1'b0), 1'b1,
            mk_event(tct_pkg::EV_UP, 32'h0, 16'h1234, 16'habcd, 1'b1, 0));
    // empty alive and closing id on an empty table: silent
    add_row(mk_item(tct_pkg::CMD_ALIVE_EMPTY, 32'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0,
                    16'h0, 16'h0, 1'b1), 1'b0, no_ev);
    add_row(mk_item(tct_pkg::CMD_ALIVE_ID, 32'h7, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0,
                    16'h0, 1'b1), 1'b0, no_ev);
    add_row(mk_item(tct_pkg::CMD_SET, 32'h7, 16'h4000, 16'hc000, 16'h0, 16'h0, 16'h0, 16'h0,
                    16'h0, 1'b0), 1'b0, no_ev);
    // same id marked twice
    add_row(mk_item(tct_pkg::CMD_ALIVE_ID, 32'h7, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0,
                    16'h0, 1'b0), 1'b0, no_ev);
    add_row(mk_item(tct_pkg::CMD_ALIVE_ID, 32'h7, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0,
                    16'h0, 1'b1), 1'b0, no_ev);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[r])
      send_item(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].ev);

    // random frames: sets, then an alive message; now and then a fill burst that
    // overruns the table, an empty alive or loose noise commands
    while (sent_items < DIRECTED_CNT + RANDOM_ITEMS) begin
      if (sent_items >= DIRECTED_CNT + RANDOM_ITEMS - CALM_TAIL) tail_calm = 1'b1;
      frame_kind = $urandom_range(0, 11);
      if (frame_kind == 0) begin
        send_item(rand_item(tct_pkg::CMD_ALIVE_EMPTY, $urandom, 1'($urandom_range(0, 1))),
                  1'b0, no_ev);
      end else if (frame_kind == 1) begin
        repeat ($urandom_range(1, 4)) begin
          sid = (tbl_cnt > 0 && $urandom_range(0, 1) == 1) ?
                tbl_id[$urandom_range(0, tbl_cnt - 1)] : pick_session_id();
          send_item(rand_item(tct_pkg::cmd_t'(2'($urandom_range(0, 3))), sid,
                              1'($urandom_range(0, 1))), 1'b0, no_ev);
        end
      end else begin
        // fill burst keeps every contact alive so the table runs full
        n_sets   = (frame_kind == 2) ? $urandom_range(8, 36) : $urandom_range(0, 6);
        keep_pct = (frame_kind == 2) ? 100 : 85;
        for (k = 0; k < n_sets; k++) begin
          sid = (tbl_cnt > 0 && $urandom_range(0, 1) == 1) ?
                tbl_id[$urandom_range(0, tbl_cnt - 1)] : pick_session_id();
          send_item(rand_item(tct_pkg::CMD_SET, sid, 1'($urandom_range(0, 1))), 1'b0, no_ev);
        end
        alive_msg.delete();
        for (k = 0; k < tbl_cnt; k++)
          if ($urandom_range(0, 99) < keep_pct)
            alive_msg.insert(alive_msg.size(),
                             rand_item(tct_pkg::CMD_ALIVE_ID, tbl_id[k], 1'b0));
        if ($urandom_range(0, 4) == 0)
          alive_msg.insert($urandom_range(0, alive_msg.size()),
                           rand_item(tct_pkg::CMD_ALIVE_ID, pick_session_id(), 1'b0));
        if ($urandom_range(0, 7) == 0)
          alive_msg.insert($urandom_range(0, alive_msg.size()),
                           rand_item(tct_pkg::CMD_SET, pick_session_id(),
                                     1'($urandom_range(0, 1))));
        if (alive_msg.size() > 0 && alive_msg[alive_msg.size() - 1].cmd == tct_pkg::CMD_SET)
          alive_msg.insert(alive_msg.size(),
                           rand_item(tct_pkg::CMD_ALIVE_ID, pick_session_id(), 1'b0));
        if (alive_msg.size() == 0) begin
          send_item(rand_item(tct_pkg::CMD_ALIVE_EMPTY, $urandom, 1'($urandom_range(0, 1))),
                    1'b0, no_ev);
        end else begin
          alive_msg[alive_msg.size() - 1].last = 1'b1;
          foreach (alive_msg[m]) send_item(alive_msg[m], 1'b0, no_ev);
        end
      end
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    // let a late stray event show up
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (pending_events.size() != 0) begin
      $display("%0d expected events never arrived", pending_events.size());
      fail_count += pending_events.size();
    end
    $display("%0d commands accepted in %0d cycles, table peaked at %0d contacts",
             sent_items, cycle_count, tbl_peak);
    $display("events checked: %0d down, %0d moved, %0d up, %0d dropped, %0d failures",
             kind_seen[tct_pkg::EV_DOWN], kind_seen[tct_pkg::EV_MOVED],
             kind_seen[tct_pkg::EV_UP], kind_seen[tct_pkg::EV_DROPPED], fail_count);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
